@@ rtl/pkcs1v15_pkg.sv @@
// shared constants, types and prefix table for the pkcs1 v1.5 signature padding check
package pkcs1v15_pkg;

	localparam int MAX_MODULUS_BYTES = 512;
	localparam int MAX_DIGEST_BYTES  = 64;
	localparam int HASH_KINDS        = 7;
	localparam int PREFIX_MAX        = 19;

	localparam int POS_W   = 10;
	localparam int LIDX_W  = $clog2(MAX_DIGEST_BYTES) + 1;
	localparam int DADDR_W = $clog2(MAX_DIGEST_BYTES);
	localparam int HASH_W  = 3;
	localparam int STAT_W  = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [POS_W-1:0]  MOD_MAX   = POS_W'(MAX_MODULUS_BYTES);
	localparam logic [POS_W-1:0]  POS_SAT   = '1;
	localparam logic [LIDX_W-1:0] LIDX_FULL = LIDX_W'(MAX_DIGEST_BYTES);

	localparam logic [POS_W-1:0] MOD_RESET  = 10'd256;
	localparam logic [HASH_W-1:0] HASH_RESET = 3'd1;

	// register index, taken from paddr bit 2
	localparam logic REG_MODULUS = 1'b0;
	localparam logic REG_HASH    = 1'b1;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_MSG  = 1'b1;

	localparam logic [7:0] BYTE_BT  = 8'h01;
	localparam logic [7:0] BYTE_PAD = 8'hff;
	localparam logic [7:0] BYTE_SEP = 8'h00;

	typedef enum logic [STAT_W-1:0] {
		ST_VALID           = 3'd0,
		ST_BAD_MSG         = 3'd1,
		ST_DIGEST_MISMATCH = 3'd2,
		ST_HASH_UNSUP      = 3'd3,
		ST_WRONG_LEN       = 3'd4
	} status_t;

	// digest store access issued by the front stage
	typedef struct packed {
		logic               we;
		logic [DADDR_W-1:0] waddr;
		logic [7:0]         wdata;
		logic               re;
		logic [DADDR_W-1:0] raddr;
	} ram_req_t;

	// message byte handed from the front stage to the compare stage
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		logic       dig_chk;
		logic       fmt_err;
		status_t    pre_status;
	} s1_t;

	localparam logic [7:0] PREFIX_ROM [0:HASH_KINDS-1][0:PREFIX_MAX-1] = '{
		'{8'h30, 8'h20, 8'h30, 8'h0c, 8'h06, 8'h08, 8'h2a, 8'h86, 8'h48, 8'h86,
		  8'hf7, 8'h0d, 8'h02, 8'h05, 8'h05, 8'h00, 8'h04, 8'h10, 8'h00},
		'{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e, 8'h03, 8'h02,
		  8'h1a, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h24, 8'h03, 8'h02,
		  8'h01, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h30, 8'h2d, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h04, 8'h05, 8'h00, 8'h04, 8'h1c},
		'{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20},
		'{8'h30, 8'h41, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h30},
		'{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40}
	};

	function automatic logic [4:0] prefix_len(input logic [HASH_W-1:0] h);
		case (h)
			3'd0:            prefix_len = 5'd18;
			3'd1, 3'd2:      prefix_len = 5'd15;
			3'd3, 3'd4, 3'd5,
			3'd6:            prefix_len = 5'd19;
			default:         prefix_len = 5'd0;
		endcase
	endfunction

	function automatic logic [6:0] digest_len(input logic [HASH_W-1:0] h);
		case (h)
			3'd0:       digest_len = 7'd16;
			3'd1, 3'd2: digest_len = 7'd20;
			3'd3:       digest_len = 7'd28;
			3'd4:       digest_len = 7'd32;
			3'd5:       digest_len = 7'd48;
			3'd6:       digest_len = 7'd64;
			default:    digest_len = 7'd0;
		endcase
	endfunction

	function automatic logic [7:0] prefix_byte(input logic [HASH_W-1:0] h,
		input logic [4:0] i);
		logic [7:0] v;
		v = 8'h00;
		if (32'(h) < HASH_KINDS && 32'(i) < PREFIX_MAX) begin
			v = PREFIX_ROM[h][i];
		end
		return v;
	endfunction

endpackage

@@ rtl/pkcs1v15_in_if.sv @@
// input channel: digest load and message bytes
interface pkcs1v15_in_if;
	import pkcs1v15_pkg::*;

	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output action, output data_byte, output last,
		input ready);
	modport sink (input valid, input action, input data_byte, input last,
		output ready);
endinterface

@@ rtl/pkcs1v15_out_if.sv @@
// output channel: one status per checked message
interface pkcs1v15_out_if;
	import pkcs1v15_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;

	modport source (output valid, output status, input ready);
	modport sink (input valid, input status, output ready);
endinterface

@@ rtl/pkcs1v15_dstore.sv @@
// expected digest memory, one write and one registered read port
module pkcs1v15_dstore (
	input  logic                  clk,
	input  pkcs1v15_pkg::ram_req_t req,
	output logic [7:0]            rdata
);
	import pkcs1v15_pkg::*;

	logic [7:0] mem [MAX_DIGEST_BYTES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end
endmodule

@@ rtl/pkcs1v15_front.sv @@
// front stage: byte position, layout decode, digest loading and store read issue
module pkcs1v15_front (
	input  logic                               clk,
	input  logic                               arst_n,
	pkcs1v15_in_if.sink                        in_ch,
	input  logic [pkcs1v15_pkg::POS_W-1:0]     modulus_bytes,
	input  logic [pkcs1v15_pkg::HASH_W-1:0]    hash_select,
	input  logic                               s1_go,
	output logic                               s1_valid,
	output pkcs1v15_pkg::s1_t                  s1,
	output pkcs1v15_pkg::ram_req_t             ram
);
	import pkcs1v15_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [LIDX_W-1:0] lidx_q;

	logic              acc_load, acc_msg;
	logic [4:0]        alen;
	logic [6:0]        dlen, info;
	logic [7:0]        need;
	logic              hash_ok, layout_ok;
	logic [POS_W-1:0]  t_off, t_sep, d_start, p_idx, d_idx, count;
	logic              fmt_err, dig_chk;
	status_t           pre_status;

	assign in_ch.ready = s1_go;
	assign acc_load = in_ch.valid && s1_go && in_ch.action == ACT_LOAD;
	assign acc_msg  = in_ch.valid && s1_go && in_ch.action == ACT_MSG;

	always_comb begin
		alen      = prefix_len(hash_select);
		dlen      = digest_len(hash_select);
		info      = 7'(alen) + dlen;
		need      = 8'(info) + 8'd11;
		hash_ok   = 32'(hash_select) < HASH_KINDS && 32'(dlen) <= MAX_DIGEST_BYTES;
		layout_ok = hash_ok && modulus_bytes <= MOD_MAX && modulus_bytes >= 10'(need);
		t_off     = modulus_bytes - 10'(info);
		t_sep     = t_off - 10'd1;
		d_start   = modulus_bytes - 10'(dlen);
		p_idx     = pos_q - t_off;
		d_idx     = pos_q - d_start;
		count     = (pos_q == POS_SAT) ? POS_SAT : pos_q + 10'd1;

		fmt_err = 1'b0;
		dig_chk = 1'b0;
		if (layout_ok && pos_q < modulus_bytes && pos_q != '0) begin
			if (pos_q == 10'd1) begin
				fmt_err = in_ch.data_byte != BYTE_BT;
			end else if (pos_q < t_sep) begin
				fmt_err = in_ch.data_byte != BYTE_PAD;
			end else if (pos_q == t_sep) begin
				fmt_err = in_ch.data_byte != BYTE_SEP;
			end else if (pos_q < d_start) begin
				fmt_err = in_ch.data_byte != prefix_byte(hash_select, p_idx[4:0]);
			end else begin
				dig_chk = 1'b1;
			end
		end

		// everything decided by registers and length alone, final bytes settle the rest
		if (!hash_ok) begin
			pre_status = ST_HASH_UNSUP;
		end else if (count != modulus_bytes || modulus_bytes > MOD_MAX) begin
			pre_status = ST_WRONG_LEN;
		end else if (modulus_bytes < 10'(need)) begin
			pre_status = ST_BAD_MSG;
		end else begin
			pre_status = ST_VALID;
		end

		ram.we    = acc_load && lidx_q < LIDX_FULL;
		ram.waddr = lidx_q[DADDR_W-1:0];
		ram.wdata = in_ch.data_byte;
		ram.re    = acc_msg;
		ram.raddr = d_idx[DADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			lidx_q   <= '0;
			s1_valid <= 1'b0;
		end else begin
			if (acc_msg) begin
				pos_q <= in_ch.last ? '0 : count;
			end
			if (acc_load) begin
				if (in_ch.last) begin
					lidx_q <= '0;
				end else if (lidx_q < LIDX_FULL) begin
					lidx_q <= lidx_q + LIDX_W'(1);
				end
			end
			if (s1_go) begin
				s1_valid <= acc_msg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_msg) begin
			s1.data_byte  <= in_ch.data_byte;
			s1.last       <= in_ch.last;
			s1.dig_chk    <= dig_chk;
			s1.fmt_err    <= fmt_err;
			s1.pre_status <= pre_status;
		end
	end
endmodule

@@ rtl/pkcs1v15_back.sv @@
// compare stage: digest compare, error flags and status output register
module pkcs1v15_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s1_valid,
	input  pkcs1v15_pkg::s1_t s1,
	input  logic [7:0]        rdata,
	output logic              s1_go,
	pkcs1v15_out_if.source    out_ch
);
	import pkcs1v15_pkg::*;

	logic    fmt_q, dig_q, out_valid_q;
	status_t status_q;
	logic    fire, fmt_now, dig_now;
	status_t status_now;

	// a final byte waits only when the status register is still occupied
	assign s1_go = !s1_valid || !s1.last || !out_valid_q || out_ch.ready;
	assign fire  = s1_valid && s1_go;

	always_comb begin
		fmt_now = fmt_q | s1.fmt_err;
		dig_now = dig_q | (s1.dig_chk && rdata != s1.data_byte);
		if (s1.pre_status != ST_VALID) begin
			status_now = s1.pre_status;
		end else if (fmt_now) begin
			status_now = ST_BAD_MSG;
		end else if (dig_now) begin
			status_now = ST_DIGEST_MISMATCH;
		end else begin
			status_now = ST_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q       <= 1'b0;
			dig_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				fmt_q <= s1.last ? 1'b0 : fmt_now;
				dig_q <= s1.last ? 1'b0 : dig_now;
			end
			if (fire && s1.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && s1.last) begin
			status_q <= status_now;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.status = status_q;
endmodule

@@ rtl/pkcs1_v15_signature_padding_check.sv @@
// top level of the pkcs1 v1.5 signature padding check
// usage:
//  - write modulus_bytes (addr 0) and hash_select (addr 4) over the apb port while idle
//  - send the expected digest on in_ch with action 0, last on its final byte
//  - then send the k bytes of the decoded block with action 1, last on the final byte
//  - one status per block leaves on out_ch: 0 valid, 1 bad message, 2 digest
//    mismatch, 3 hash unsupported, 4 wrong length
// timing:
//  - one transaction per cycle is taken on in_ch while in_ch ready is high, loads and message bytes alike
//  - the final message byte and the digest memory read it issues are registered
//    when the byte is accepted; the compare result is then registered in the
//    output register, which waits while that register is still occupied
// reset:
//  - clears byte position, load index, error flags and output valid
//  - registers return to k = 256 and sha1; the digest memory is not cleared
// stall:
//  - while out_ch is stalled the block keeps taking bytes; only a final byte
//    that meets a still occupied status register holds in_ch ready low
module pkcs1_v15_signature_padding_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pkcs1v15_pkg::PADDR_W-1:0]   paddr,
	input  logic [pkcs1v15_pkg::PDATA_W-1:0]   pwdata,
	output logic [pkcs1v15_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	pkcs1v15_in_if.sink                        in_ch,
	pkcs1v15_out_if.source                     out_ch
);
	import pkcs1v15_pkg::*;

	logic [POS_W-1:0]  modulus_q;
	logic [HASH_W-1:0] hash_q;
	logic              s1_go, s1_valid;
	s1_t               s1;
	ram_req_t          ram;
	logic [7:0]        rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET;
			hash_q    <= HASH_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_MODULUS: modulus_q <= pwdata[POS_W-1:0];
				REG_HASH:    hash_q    <= pwdata[HASH_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MODULUS: prdata = PDATA_W'(modulus_q);
			REG_HASH:    prdata = PDATA_W'(hash_q);
			default:     prdata = '0;
		endcase
	end

	pkcs1v15_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.modulus_bytes (modulus_q),
		.hash_select   (hash_q),
		.s1_go         (s1_go),
		.s1_valid      (s1_valid),
		.s1            (s1),
		.ram           (ram)
	);

	pkcs1v15_dstore u_dstore (
		.clk   (clk),
		.req   (ram),
		.rdata (rdata)
	);

	pkcs1v15_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.s1       (s1),
		.rdata    (rdata),
		.s1_go    (s1_go),
		.out_ch   (out_ch)
	);
endmodule

@@ verif/pkcs1_v15_signature_padding_check_test.sv @@
// testbench for the pkcs1 v1.5 signature padding check: predicted status compared per message
module pkcs1_v15_signature_padding_check_test;
	import pkcs1v15_pkg::*;

	localparam int CLK_HALF       = 10;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RUN_LIMIT      = 20_000_000;
	localparam int TARGET_ITEMS   = 1600;

	localparam logic [PADDR_W-1:0] ADDR_MODULUS = {REG_MODULUS, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_HASH    = {REG_HASH, 2'b00};

	localparam logic [HASH_W-1:0] HASH_MD5    = 3'd0;
	localparam logic [HASH_W-1:0] HASH_SHA1   = 3'd1;
	localparam logic [HASH_W-1:0] HASH_SHA512 = 3'd6;
	localparam logic [HASH_W-1:0] HASH_NONE   = 3'd7;

	// digestinfo headers per hash
	localparam logic [7:0] DI_PREFIX [0:6][0:18] = '{
		'{8'h30, 8'h20, 8'h30, 8'h0c, 8'h06, 8'h08, 8'h2a, 8'h86, 8'h48, 8'h86,
		  8'hf7, 8'h0d, 8'h02, 8'h05, 8'h05, 8'h00, 8'h04, 8'h10, 8'h00},
		'{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e, 8'h03, 8'h02,
		  8'h1a, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h24, 8'h03, 8'h02,
		  8'h01, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h30, 8'h2d, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h04, 8'h05, 8'h00, 8'h04, 8'h1c},
		'{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20},
		'{8'h30, 8'h41, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h30},
		'{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40}
	};

	typedef enum int {
		MSG_GOOD, MSG_FLIP, MSG_DIGEST_FLIP, MSG_SHORT, MSG_LONG, MSG_NOISE
	} msg_kind_t;

	class sig_status_scoreboard;
		logic [7:0]        digest_mem [MAX_DIGEST_BYTES];
		int                load_idx;
		int                pos;
		bit                fmt_bad;
		bit                dig_bad;
		logic [POS_W-1:0]  k;
		logic [HASH_W-1:0] hsel;
		logic [STAT_W-1:0] pending_status [$];
		int                items;
		int                results;
		int                failures;

		function new();
			foreach (digest_mem[i]) digest_mem[i] = 8'h00;
			load_idx = 0;
			pos      = 0;
			fmt_bad  = 1'b0;
			dig_bad  = 1'b0;
			k        = MOD_RESET;
			hsel     = HASH_RESET;
			items    = 0;
			results  = 0;
			failures = 0;
		endfunction

		function int pfx_bytes(logic [HASH_W-1:0] h);
			case (h)
				3'd0:             return 18;
				3'd1, 3'd2:       return 15;
				3'd3, 3'd4, 3'd5,
				3'd6:             return 19;
				default:          return 0;
			endcase
		endfunction

		function int dig_bytes(logic [HASH_W-1:0] h);
			case (h)
				3'd0:       return 16;
				3'd1, 3'd2: return 20;
				3'd3:       return 28;
				3'd4:       return 32;
				3'd5:       return 48;
				3'd6:       return 64;
				default:    return 0;
			endcase
		endfunction

		function bit hash_supported();
			return int'(hsel) < HASH_KINDS && dig_bytes(hsel) <= MAX_DIGEST_BYTES;
		endfunction

		// predicts the effect of one accepted transaction
		function void note_input(logic act, logic [7:0] b, logic lst);
			int      p;
			int      kk;
			int      plen;
			int      ilen;
			int      t_off;
			int      d;
			status_t st;
			items++;
			if (act == ACT_LOAD) begin
				if (load_idx < MAX_DIGEST_BYTES) begin
					digest_mem[load_idx] = b;
					load_idx++;
				end
				if (lst)
					load_idx = 0;
				return;
			end
			p     = pos;
			kk    = int'(k);
			plen  = pfx_bytes(hsel);
			ilen  = plen + dig_bytes(hsel);
			t_off = kk - ilen;
			if (hash_supported() && kk <= MAX_MODULUS_BYTES && kk >= ilen + 11 && p < kk) begin
				if (p == 0) begin
				end else if (p == 1) begin
					if (b != BYTE_BT) fmt_bad = 1'b1;
				end else if (p < t_off - 1) begin
					if (b != BYTE_PAD) fmt_bad = 1'b1;
				end else if (p == t_off - 1) begin
					if (b != BYTE_SEP) fmt_bad = 1'b1;
				end else if (p < t_off + plen) begin
					if (b != DI_PREFIX[hsel][p - t_off]) fmt_bad = 1'b1;
				end else begin
					d = p - t_off - plen;
					if (d < MAX_DIGEST_BYTES && b != digest_mem[d]) dig_bad = 1'b1;
				end
			end
			pos = (p + 1 > int'(POS_SAT)) ? int'(POS_SAT) : p + 1;
			if (!lst)
				return;
			if (!hash_supported())
				st = ST_HASH_UNSUP;
			else if (p + 1 != kk || kk > MAX_MODULUS_BYTES)
				st = ST_WRONG_LEN;
			else if (kk < ilen + 11 || fmt_bad)
				st = ST_BAD_MSG;
			else if (dig_bad)
				st = ST_DIGEST_MISMATCH;
			else
				st = ST_VALID;
			pending_status.push_back(st);
			pos     = 0;
			fmt_bad = 1'b0;
			dig_bad = 1'b0;
		endfunction

		function void check_result(logic [STAT_W-1:0] got);
			logic [STAT_W-1:0] want;
			results++;
			if (pending_status.size() == 0) begin
				failures++;
				$display("%0t: status expected none, actual %0d", $time, got);
			end else begin
				want = pending_status.pop_front();
				if (got !== want) begin
					failures++;
					$display("%0t: status expected %0d, actual %0d", $time, want, got);
				end
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	pkcs1v15_in_if  in_ch ();
	pkcs1v15_out_if out_ch ();

	pkcs1_v15_signature_padding_check u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	sig_status_scoreboard sb;
	int burst_left = 0;
	int rx_mode    = 0;
	int rx_left    = 0;

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// receiver stall pattern: always ready, random, or periodic stall runs
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(20, 150);
		end
		rx_left--;
		case (rx_mode)
			0:       out_ch.ready = 1'b1;
			1:       out_ch.ready = ($urandom_range(0, 3) != 0);
			default: out_ch.ready = ((rx_left % 23) > 6);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			sb.check_result(out_ch.status);
	end

	initial begin
		#(RUN_LIMIT);
		$display("pkcs1_v15_signature_padding_check_test NOT OK");
		$finish;
	end

	task automatic send_byte(logic act, logic [7:0] b, logic lst);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		in_ch.valid     = 1'b1;
		in_ch.action    = act;
		in_ch.data_byte = b;
		in_ch.last      = lst;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_input(act, b, lst);
		burst_left--;
	endtask

	// stop sending and let every pending status come out
	task automatic quiesce();
		@(negedge clk);
		in_ch.valid = 1'b0;
		burst_left  = 0;
		while (sb.pending_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] want;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (addr == ADDR_MODULUS) begin
			sb.k = value[POS_W-1:0];
			want = PDATA_W'(sb.k);
		end else begin
			sb.hsel = value[HASH_W-1:0];
			want = PDATA_W'(sb.hsel);
		end
		// read the register back
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== want) begin
			sb.failures++;
			$display("%0t: register %0d read expected %0h, actual %0h", $time, addr, want,
				prdata);
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_config(int k_val, logic [HASH_W-1:0] h_val);
		logic [PDATA_W-1:0] v;
		quiesce();
		// upper bits carry junk, only the register width counts
		v = $urandom();
		v[POS_W-1:0] = POS_W'(k_val);
		write_reg(ADDR_MODULUS, v);
		v = $urandom();
		v[HASH_W-1:0] = h_val;
		write_reg(ADDR_HASH, v);
	endtask

	task automatic load_digest(int n, bit with_last);
		for (int i = 0; i < n; i++)
			send_byte(ACT_LOAD, 8'($urandom_range(0, 255)), with_last && i == n - 1);
	endtask

	// builds a block for the current registers and sends it; flip_at picks the byte
	task automatic send_message(msg_kind_t kind, int flip_at = -1, int extra = 0);
		logic [7:0] msg [$];
		int kk;
		int plen;
		int dlen;
		int t_off;
		int idx;
		int n;
		kk    = int'(sb.k);
		plen  = sb.pfx_bytes(sb.hsel);
		dlen  = sb.dig_bytes(sb.hsel);
		t_off = kk - plen - dlen;
		for (int i = 0; i < kk; i++) begin
			if (kind == MSG_NOISE || i == 0)
				msg.push_back(8'($urandom_range(0, 255)));
			else if (i == 1)
				msg.push_back(BYTE_BT);
			else if (i < t_off - 1)
				msg.push_back(BYTE_PAD);
			else if (i == t_off - 1)
				msg.push_back(BYTE_SEP);
			else if (i < t_off + plen)
				msg.push_back(DI_PREFIX[sb.hsel][i - t_off]);
			else if (i - t_off - plen < MAX_DIGEST_BYTES)
				msg.push_back(sb.digest_mem[i - t_off - plen]);
			else
				msg.push_back(8'($urandom_range(0, 255)));
		end
		case (kind)
			MSG_FLIP: begin
				idx = (flip_at >= 0) ? flip_at : $urandom_range(0, kk > 0 ? kk - 1 : 0);
				if (idx < msg.size())
					msg[idx] = msg[idx] ^ 8'($urandom_range(1, 255));
			end
			MSG_DIGEST_FLIP: begin
				if (dlen > 0) begin
					idx = kk - 1 - $urandom_range(0, dlen - 1);
					if (idx >= 0)
						msg[idx] = msg[idx] ^ 8'($urandom_range(1, 255));
				end
			end
			MSG_SHORT: begin
				if (msg.size() > 1) begin
					n = $urandom_range(1, msg.size() - 1 < 3 ? msg.size() - 1 : 3);
					repeat (n) void'(msg.pop_back());
				end
			end
			MSG_LONG: begin
				n = (extra > 0) ? extra : $urandom_range(1, 3);
				repeat (n) msg.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
			end
		endcase
		if (msg.size() == 0)
			msg.push_back(8'($urandom_range(0, 255)));
		foreach (msg[i])
			send_byte(ACT_MSG, msg[i], i == msg.size() - 1);
	endtask

	initial begin
		int               start_items;
		int               kmin;
		int               kk;
		int               r;
		logic [HASH_W-1:0] h;
		msg_kind_t        kind;

		sb              = new();
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		in_ch.valid     = 1'b0;
		in_ch.action    = ACT_LOAD;
		in_ch.data_byte = 8'h00;
		in_ch.last      = 1'b0;
		out_ch.ready    = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the whole digest store so no unwritten entry is ever compared
		load_digest(MAX_DIGEST_BYTES, 1'b1);

		// reset registers: k = 256, sha1
		send_message(MSG_GOOD);
		set_config(45, HASH_MD5);
		send_message(MSG_GOOD);
		send_message(MSG_FLIP, 1);
		send_message(MSG_FLIP, 2);
		send_message(MSG_FLIP, 45 - 34 - 1);
		send_message(MSG_FLIP, 45 - 34);
		send_message(MSG_DIGEST_FLIP);
		send_message(MSG_SHORT);
		send_message(MSG_LONG);
		// short modulus
		set_config(44, HASH_MD5);
		send_message(MSG_GOOD);
		set_config(60, HASH_NONE);
		send_message(MSG_GOOD);
		set_config(MAX_MODULUS_BYTES, HASH_SHA512);
		send_message(MSG_GOOD);
		// more than 64 load bytes, the tail is dropped
		load_digest(70, 1'b1);
		set_config(94, HASH_SHA512);
		send_message(MSG_GOOD);
		// a load run without last continues where it stopped
		load_digest(10, 1'b0);
		load_digest(12, 1'b1);
		send_message(MSG_GOOD);
		// oversized modulus and byte position saturation
		set_config(1023, HASH_SHA1);
		send_message(MSG_LONG, -1, 7);
		set_config(0, HASH_SHA1);
		send_message(MSG_GOOD);

		start_items = sb.items;
		h = HASH_SHA1;
		while (sb.items - start_items < TARGET_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				h    = HASH_W'($urandom_range(0, 7));
				kmin = sb.pfx_bytes(h) + sb.dig_bytes(h) + 11;
				r    = $urandom_range(0, 19);
				if (r < 14)
					kk = kmin + $urandom_range(0, 24);
				else if (r < 16)
					kk = kmin - $urandom_range(1, 10);
				else if (r < 18)
					kk = $urandom_range(0, 60);
				else if (r == 18)
					kk = MAX_MODULUS_BYTES;
				else
					kk = $urandom_range(0, 1023);
				set_config(kk, h);
			end else if ($urandom_range(0, 5) == 0) begin
				quiesce();
			end
			if ($urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 3) == 0)
					load_digest($urandom_range(1, 80), $urandom_range(0, 3) != 0);
				else
					load_digest(sb.dig_bytes(sb.hsel) > 0 ? sb.dig_bytes(sb.hsel) : 16, 1'b1);
			end
			repeat ((int'(sb.k) > 200) ? 1 : $urandom_range(1, 4)) begin
				r = $urandom_range(0, 19);
				if (r < 9)
					kind = MSG_GOOD;
				else if (r < 12)
					kind = MSG_FLIP;
				else if (r < 15)
					kind = MSG_DIGEST_FLIP;
				else if (r < 17)
					kind = MSG_SHORT;
				else if (r < 18)
					kind = MSG_LONG;
				else
					kind = MSG_NOISE;
				send_message(kind);
			end
		end

		@(negedge clk);
		in_ch.valid = 1'b0;
		while (sb.pending_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("pkcs1_v15_signature_padding_check_test OK");
		else
			$display("pkcs1_v15_signature_padding_check_test NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/pkcs1v15_pkg.sv
rtl/pkcs1v15_in_if.sv
rtl/pkcs1v15_out_if.sv
rtl/pkcs1v15_dstore.sv
rtl/pkcs1v15_front.sv
rtl/pkcs1v15_back.sv
rtl/pkcs1_v15_signature_padding_check.sv
verif/pkcs1_v15_signature_padding_check_test.sv
